// ===== rtl/nel_pkg.sv =====
// Shared types, widths, scale tables and helper functions for the evaporation loss nomograph.
`timescale 1ns / 1ps

package nel_pkg;

    localparam int IW  = 16;   // measurement width, unsigned Q8.8
    localparam int HW  = 19;   // scale height, signed Q1.16 with headroom
    localparam int XW  = 20;   // breakpoint compare width, signed
    localparam int OW  = 14;   // segment offset / divisor width
    localparam int RW  = 23;   // reciprocal width
    localparam int PW  = 27;   // product magnitude width, reciprocal shift
    localparam int SW  = 4;    // segment index width
    localparam int LW  = 14;   // loss percent width
    localparam int NT  = 15;   // padded table length
    localparam int NS  = 20;   // pipeline register stages

    localparam int DIV_ONE = 1 << PW;

    localparam int COL_A_NUM = 237;
    localparam int COL_A_DEN = 439;
    localparam int COL_B_NUM = 132;
    localparam int COL_B_DEN = 262;
    localparam int COL_L_NUM = 253;
    localparam int COL_L_DEN = 633;

    typedef logic signed [XW-1:0] xval_t;
    typedef logic signed [HW-1:0] hval_t;
    typedef int itab_t [NT];

    // operands of one truncating divide step: base + trunc(a * b / w)
    typedef struct packed {
        hval_t           a;
        logic [OW-1:0]   b;
        hval_t           base;
        logic [OW-1:0]   w;
        logic [RW-1:0]   r;
    } div_in_t;

    localparam int VPD_N  = 11;
    localparam int NOZ_N  = 11;
    localparam int PRES_N = 11;
    localparam int WIND_N = 15;
    localparam int LOSS_N = 14;

    localparam itab_t VPD_X = '{0, 26, 51, 77, 102, 128, 154, 179, 205, 230, 256,
                                256, 256, 256, 256};
    localparam itab_t VPD_Y = '{0, 14483, 24969, 33292, 40174, 45548, 49938, 54329,
                                58130, 62194, 65536, 65536, 65536, 65536, 65536};
    localparam itab_t VPD_R = '{1, DIV_ONE / 26, DIV_ONE / 25, DIV_ONE / 26, DIV_ONE / 25,
                                DIV_ONE / 26, DIV_ONE / 26, DIV_ONE / 25, DIV_ONE / 26,
                                DIV_ONE / 25, DIV_ONE / 26, 1, 1, 1, 1};

    localparam itab_t NOZ_X = '{2048, 2560, 3072, 3584, 4096, 5120, 6144, 8192, 10240,
                                12288, 16384, 16384, 16384, 16384, 16384};
    localparam itab_t NOZ_Y = '{65667, 58655, 53412, 48628, 44237, 36897, 31654, 23069,
                                15270, 9961, -66, -66, -66, -66, -66};
    localparam itab_t NOZ_R = '{1, DIV_ONE / 512, DIV_ONE / 512, DIV_ONE / 512,
                                DIV_ONE / 512, DIV_ONE / 1024, DIV_ONE / 1024,
                                DIV_ONE / 2048, DIV_ONE / 2048, DIV_ONE / 2048,
                                DIV_ONE / 4096, 1, 1, 1, 1};

    localparam itab_t PRES_X = '{5120, 6400, 7680, 8960, 10240, 11520, 12800, 14080,
                                 15360, 17920, 20480, 20480, 20480, 20480, 20480};
    localparam itab_t PRES_Y = '{0, 10420, 19399, 26673, 32702, 38601, 43581, 48169,
                                 52429, 58982, 65274, 65274, 65274, 65274, 65274};
    localparam itab_t PRES_R = '{1, DIV_ONE / 1280, DIV_ONE / 1280, DIV_ONE / 1280,
                                 DIV_ONE / 1280, DIV_ONE / 1280, DIV_ONE / 1280,
                                 DIV_ONE / 1280, DIV_ONE / 1280, DIV_ONE / 2560,
                                 DIV_ONE / 2560, 1, 1, 1, 1};

    localparam itab_t WIND_X = '{0, 256, 512, 768, 1024, 1280, 1536, 1792, 2048, 2304,
                                 2560, 2816, 3072, 3328, 3840};
    localparam itab_t WIND_Y = '{0, 9175, 16122, 23331, 28508, 33292, 37880, 42664,
                                 46268, 49807, 53150, 55968, 58655, 60948, 65143};
    localparam itab_t WIND_R = '{1, DIV_ONE / 256, DIV_ONE / 256, DIV_ONE / 256,
                                 DIV_ONE / 256, DIV_ONE / 256, DIV_ONE / 256,
                                 DIV_ONE / 256, DIV_ONE / 256, DIV_ONE / 256,
                                 DIV_ONE / 256, DIV_ONE / 256, DIV_ONE / 256,
                                 DIV_ONE / 256, DIV_ONE / 512};

    localparam itab_t LOSS_X = '{6685, 16515, 23593, 30147, 34144, 36897, 39256, 41484,
                                 43975, 46006, 49676, 53215, 57868, 60097, 60097};
    localparam itab_t LOSS_Y = '{0, 128, 256, 512, 768, 1024, 1280, 1536, 2048, 2560,
                                 3840, 5120, 7680, 10240, 10240};
    localparam itab_t LOSS_R = '{1, DIV_ONE / 9830, DIV_ONE / 7078, DIV_ONE / 6554,
                                 DIV_ONE / 3997, DIV_ONE / 2753, DIV_ONE / 2359,
                                 DIV_ONE / 2228, DIV_ONE / 2491, DIV_ONE / 2031,
                                 DIV_ONE / 3670, DIV_ONE / 3539, DIV_ONE / 4653,
                                 DIV_ONE / 2229, 1};

    // segment i spans xs[i-1] .. xs[i]
    function automatic logic [SW-1:0] seg_find(input xval_t q, input itab_t xs,
                                               input int n);
        logic [SW-1:0] cnt;
        cnt = SW'(1);
        for (int k = 1; k < NT - 1; k++) begin
            if (k <= n - 2 && q > xval_t'(xs[k])) begin
                cnt = cnt + 1'b1;
            end
        end
        return cnt;
    endfunction

    // offset into the segment, clamped to its span
    function automatic logic [OW-1:0] seg_off(input xval_t q, input itab_t xs,
                                              input logic [SW-1:0] seg);
        xval_t d;
        xval_t w;
        logic [OW-1:0] res;
        d = q - xval_t'(xs[seg - SW'(1)]);
        w = xval_t'(xs[seg]) - xval_t'(xs[seg - SW'(1)]);
        if (d < 0) begin
            res = '0;
        end
        else if (d > w) begin
            res = w[OW-1:0];
        end
        else begin
            res = d[OW-1:0];
        end
        return res;
    endfunction

    function automatic div_in_t seg_args(input logic [SW-1:0] seg, input logic [OW-1:0] off,
                                         input itab_t xs, input itab_t ys, input itab_t rs);
        div_in_t res;
        res.a    = hval_t'(ys[seg] - ys[seg - SW'(1)]);
        res.b    = off;
        res.base = hval_t'(ys[seg - SW'(1)]);
        res.w    = OW'(xs[seg] - xs[seg - SW'(1)]);
        res.r    = RW'(rs[seg]);
        return res;
    endfunction

endpackage

// ===== rtl/nel_div.sv =====
// Four-stage pipelined signed scale-and-divide: y = base + trunc(a * b / w).
`timescale 1ns / 1ps

module nel_div
    import nel_pkg::*;
(
    input  logic         clk,
    input  logic [3:0]   en,
    input  div_in_t      din,
    output hval_t        y
);

    // stage 1: magnitude product
    logic [PW-1:0]     mag1_reg, mag1_next;
    logic              neg1_reg, neg1_next;
    hval_t             base1_reg;
    logic [OW-1:0]     w1_reg;
    logic [RW-1:0]     r1_reg;
    logic [HW-1:0]     a_mag;
    logic [HW+OW-1:0]  prod1;

    // stage 2: reciprocal estimate
    logic [PW-1:0]     mag2_reg;
    logic              neg2_reg;
    hval_t             base2_reg;
    logic [OW-1:0]     w2_reg;
    logic [RW-1:0]     q2_reg, q2_next;
    logic [PW+RW-1:0]  prod2;

    // stage 3: back product
    logic [PW-1:0]     mag3_reg;
    logic              neg3_reg;
    hval_t             base3_reg;
    logic [OW-1:0]     w3_reg;
    logic [RW-1:0]     q3_reg;
    logic [PW-1:0]     qw3_reg, qw3_next;
    logic [RW+OW-1:0]  prod3;

    // stage 4: correction and sign
    logic [PW-1:0]     rem;
    logic [RW-1:0]     quo;
    hval_t             quo_h;
    hval_t             y_reg, y_next;

    always_comb
    begin
        a_mag     = din.a[HW-1] ? HW'(-din.a) : HW'(din.a);
        prod1     = a_mag * din.b;
        mag1_next = prod1[PW-1:0];
        neg1_next = din.a[HW-1];

        prod2     = mag1_reg * r1_reg;
        q2_next   = prod2[PW+RW-1:PW];

        prod3     = q2_reg * w2_reg;
        qw3_next  = prod3[PW-1:0];

        rem       = mag3_reg - qw3_reg;
        quo       = (rem >= PW'(w3_reg)) ? q3_reg + 1'b1 : q3_reg;
        quo_h     = hval_t'(quo[HW-1:0]);
        y_next    = neg3_reg ? base3_reg - quo_h : base3_reg + quo_h;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            mag1_reg  <= mag1_next;
            neg1_reg  <= neg1_next;
            base1_reg <= din.base;
            w1_reg    <= din.w;
            r1_reg    <= din.r;
        end
        if (en[1])
        begin
            mag2_reg  <= mag1_reg;
            neg2_reg  <= neg1_reg;
            base2_reg <= base1_reg;
            w2_reg    <= w1_reg;
            q2_reg    <= q2_next;
        end
        if (en[2])
        begin
            mag3_reg  <= mag2_reg;
            neg3_reg  <= neg2_reg;
            base3_reg <= base2_reg;
            w3_reg    <= w2_reg;
            q3_reg    <= q2_reg;
            qw3_reg   <= qw3_next;
        end
        if (en[3])
        begin
            y_reg     <= y_next;
        end
    end

    assign y = y_reg;

endmodule

// ===== rtl/nomograph_evaporation_loss.sv =====
// Top level: pipelined nomograph evaluator from four measurements to evaporation loss.
// Throughput: one transfer per cycle while m_tready holds; 20 register stages, each with its own valid bit.
// A stage is refilled whenever it is empty or its successor moves, so bubbles collapse.
// Each interpolation and column ratio uses a 4-stage reciprocal divide with correction.
// rst_n clears all valid bits asynchronously; data registers are not reset.
`timescale 1ns / 1ps

module nomograph_evaporation_loss
    import nel_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // vapor_deficit, nozzle_size, line_pressure, wind_speed
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // loss_percent, 2'b0
);

    logic [NS-1:0]  v_reg, v_next;
    logic [NS-1:0]  en;

    xval_t          q_in [4];
    logic [SW-1:0]  seg_reg [4];
    logic [SW-1:0]  seg_next [4];
    logic [OW-1:0]  off_reg [4];
    logic [OW-1:0]  off_next [4];

    div_in_t        din_vpd, din_noz, din_pres, din_wind;
    hval_t          h_vpd, h_noz, h_pres, h_wind;

    hval_t          diff_a_reg, diff_a_next, base_a_reg;
    hval_t          diff_b_reg, diff_b_next, base_b_reg;
    div_in_t        din_a, din_b;
    hval_t          piv_a, piv_b;

    hval_t          diff_l_reg, diff_l_next, base_l_reg;
    div_in_t        din_l;
    hval_t          h_line;

    xval_t          q_loss;
    logic [SW-1:0]  lseg_reg, lseg_next;
    logic [OW-1:0]  loff_reg, loff_next;
    div_in_t        din_loss;
    hval_t          loss_y;

    // stage enables, back to front
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || m_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next[0] = en[0] ? s_tvalid : v_reg[0];
        for (int k = 1; k < NS; k++) begin
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[NS-1];

    // stage 0: segment select on the four scales
    always_comb
    begin
        for (int i = 0; i < 4; i++) begin
            q_in[i] = xval_t'({{(XW-IW){1'b0}}, s_tdata[IW*i +: IW]});
        end
        seg_next[0] = seg_find(q_in[0], VPD_X, VPD_N);
        seg_next[1] = seg_find(q_in[1], NOZ_X, NOZ_N);
        seg_next[2] = seg_find(q_in[2], PRES_X, PRES_N);
        seg_next[3] = seg_find(q_in[3], WIND_X, WIND_N);
        off_next[0] = seg_off(q_in[0], VPD_X, seg_next[0]);
        off_next[1] = seg_off(q_in[1], NOZ_X, seg_next[1]);
        off_next[2] = seg_off(q_in[2], PRES_X, seg_next[2]);
        off_next[3] = seg_off(q_in[3], WIND_X, seg_next[3]);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            seg_reg <= seg_next;
            off_reg <= off_next;
        end
    end

    // stages 1-4: scale heights
    always_comb
    begin
        din_vpd  = seg_args(seg_reg[0], off_reg[0], VPD_X, VPD_Y, VPD_R);
        din_noz  = seg_args(seg_reg[1], off_reg[1], NOZ_X, NOZ_Y, NOZ_R);
        din_pres = seg_args(seg_reg[2], off_reg[2], PRES_X, PRES_Y, PRES_R);
        din_wind = seg_args(seg_reg[3], off_reg[3], WIND_X, WIND_Y, WIND_R);
    end

    nel_div u_div_vpd  (.clk(clk), .en(en[4:1]), .din(din_vpd),  .y(h_vpd));
    nel_div u_div_noz  (.clk(clk), .en(en[4:1]), .din(din_noz),  .y(h_noz));
    nel_div u_div_pres (.clk(clk), .en(en[4:1]), .din(din_pres), .y(h_pres));
    nel_div u_div_wind (.clk(clk), .en(en[4:1]), .din(din_wind), .y(h_wind));

    // stage 5: pivot differences
    assign diff_a_next = h_noz - h_vpd;
    assign diff_b_next = h_wind - h_pres;

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            diff_a_reg <= diff_a_next;
            base_a_reg <= h_vpd;
            diff_b_reg <= diff_b_next;
            base_b_reg <= h_pres;
        end
    end

    // stages 6-9: pivot heights
    always_comb
    begin
        din_a.a    = diff_a_reg;
        din_a.b    = OW'(COL_A_NUM);
        din_a.base = base_a_reg;
        din_a.w    = OW'(COL_A_DEN);
        din_a.r    = RW'(DIV_ONE / COL_A_DEN);
        din_b.a    = diff_b_reg;
        din_b.b    = OW'(COL_B_NUM);
        din_b.base = base_b_reg;
        din_b.w    = OW'(COL_B_DEN);
        din_b.r    = RW'(DIV_ONE / COL_B_DEN);
    end

    nel_div u_div_a (.clk(clk), .en(en[9:6]), .din(din_a), .y(piv_a));
    nel_div u_div_b (.clk(clk), .en(en[9:6]), .din(din_b), .y(piv_b));

    // stage 10: loss column difference
    assign diff_l_next = piv_b - piv_a;

    always_ff @(posedge clk)
    begin
        if (en[10])
        begin
            diff_l_reg <= diff_l_next;
            base_l_reg <= piv_a;
        end
    end

    // stages 11-14: height on the loss column
    always_comb
    begin
        din_l.a    = diff_l_reg;
        din_l.b    = OW'(COL_L_NUM);
        din_l.base = base_l_reg;
        din_l.w    = OW'(COL_L_DEN);
        din_l.r    = RW'(DIV_ONE / COL_L_DEN);
    end

    nel_div u_div_l (.clk(clk), .en(en[14:11]), .din(din_l), .y(h_line));

    // stage 15: loss scale segment select
    always_comb
    begin
        q_loss    = xval_t'({{(XW-HW){h_line[HW-1]}}, h_line});
        lseg_next = seg_find(q_loss, LOSS_X, LOSS_N);
        loff_next = seg_off(q_loss, LOSS_X, lseg_next);
    end

    always_ff @(posedge clk)
    begin
        if (en[15])
        begin
            lseg_reg <= lseg_next;
            loff_reg <= loff_next;
        end
    end

    // stages 16-19: reverse lookup; table ends already bound the result to 0..40
    assign din_loss = seg_args(lseg_reg, loff_reg, LOSS_X, LOSS_Y, LOSS_R);

    nel_div u_div_loss (.clk(clk), .en(en[19:16]), .din(din_loss), .y(loss_y));

    assign m_tdata = {{(16-LW){1'b0}}, loss_y[LW-1:0]};

endmodule

// ===== sim/nomograph_evaporation_loss_checker.sv =====
// Checker for the evaporation loss nomograph: predicts each loss result and compares.
`timescale 1ns / 1ps

module nomograph_evaporation_loss_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // vapor_deficit, nozzle_size, line_pressure, wind_speed
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // loss_percent, 2'b0
    output int          fail_count,
    output int          outstanding,
    output int          results_checked,
    output int          clamp_low,
    output int          clamp_high
);

    typedef longint scale_tab_t [15];

    // breakpoints (Q8.8) and heights (Q1.16), padded with the last entry
    localparam scale_tab_t VPD_AT = '{0, 26, 51, 77, 102, 128, 154, 179, 205, 230, 256,
                                      256, 256, 256, 256};
    localparam scale_tab_t VPD_HT = '{0, 14483, 24969, 33292, 40174, 45548, 49938, 54329,
                                      58130, 62194, 65536, 65536, 65536, 65536, 65536};
    localparam scale_tab_t NOZ_AT = '{2048, 2560, 3072, 3584, 4096, 5120, 6144, 8192, 10240,
                                      12288, 16384, 16384, 16384, 16384, 16384};
    localparam scale_tab_t NOZ_HT = '{65667, 58655, 53412, 48628, 44237, 36897, 31654, 23069,
                                      15270, 9961, -66, -66, -66, -66, -66};
    localparam scale_tab_t PRES_AT = '{5120, 6400, 7680, 8960, 10240, 11520, 12800, 14080,
                                       15360, 17920, 20480, 20480, 20480, 20480, 20480};
    localparam scale_tab_t PRES_HT = '{0, 10420, 19399, 26673, 32702, 38601, 43581, 48169,
                                       52429, 58982, 65274, 65274, 65274, 65274, 65274};
    localparam scale_tab_t WIND_AT = '{0, 256, 512, 768, 1024, 1280, 1536, 1792, 2048, 2304,
                                       2560, 2816, 3072, 3328, 3840};
    localparam scale_tab_t WIND_HT = '{0, 9175, 16122, 23331, 28508, 33292, 37880, 42664,
                                       46268, 49807, 53150, 55968, 58655, 60948, 65143};
    // loss scale read backwards: height in, percent (Q8.8) out
    localparam scale_tab_t LOSS_HT = '{6685, 16515, 23593, 30147, 34144, 36897, 39256, 41484,
                                       43975, 46006, 49676, 53215, 57868, 60097, 60097};
    localparam scale_tab_t LOSS_PCT = '{0, 128, 256, 512, 768, 1024, 1280, 1536, 2048, 2560,
                                        3840, 5120, 7680, 10240, 10240};

    localparam longint PIVOT_A_NUM = 237;
    localparam longint PIVOT_A_DEN = 439;
    localparam longint PIVOT_B_NUM = 132;
    localparam longint PIVOT_B_DEN = 262;
    localparam longint LINE_NUM    = 253;
    localparam longint LINE_DEN    = 633;
    localparam longint LOSS_MAX    = 10240;

    typedef struct packed {
        logic [63:0] meas;
        logic [13:0] loss;
    } loss_entry_t;

    loss_entry_t loss_expected [$];

    function automatic longint scale_height(input longint q, input scale_tab_t xs,
                                            input scale_tab_t ys, input int n);
        int seg;
        seg = n - 1;
        if (q <= xs[0])
            return ys[0];
        if (q >= xs[n-1])
            return ys[n-1];
        for (int k = n - 2; k >= 1; k--)
        begin
            if (xs[k] >= q)
                seg = k;
        end
        return ys[seg-1] + ((ys[seg] - ys[seg-1]) * (q - xs[seg-1])) / (xs[seg] - xs[seg-1]);
    endfunction

    function automatic logic [13:0] predict_loss(input logic [63:0] d);
        longint h_vpd;
        longint h_noz;
        longint h_pres;
        longint h_wind;
        longint piv_a;
        longint piv_b;
        longint h_line;
        longint loss;
        h_vpd  = scale_height(longint'(d[15:0]),  VPD_AT,  VPD_HT,  11);
        h_noz  = scale_height(longint'(d[31:16]), NOZ_AT,  NOZ_HT,  11);
        h_pres = scale_height(longint'(d[47:32]), PRES_AT, PRES_HT, 11);
        h_wind = scale_height(longint'(d[63:48]), WIND_AT, WIND_HT, 15);
        piv_a  = h_vpd + ((h_noz - h_vpd) * PIVOT_A_NUM) / PIVOT_A_DEN;
        piv_b  = h_pres + ((h_wind - h_pres) * PIVOT_B_NUM) / PIVOT_B_DEN;
        h_line = piv_a + ((piv_b - piv_a) * LINE_NUM) / LINE_DEN;
        loss   = scale_height(h_line, LOSS_HT, LOSS_PCT, 14);
        if (loss < 0)
            loss = 0;
        if (loss > LOSS_MAX)
            loss = LOSS_MAX;
        return 14'(loss);
    endfunction

    always @(posedge clk)
    begin : watch
        loss_entry_t want;
        loss_entry_t fresh;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (loss_expected.size() == 0)
                begin
                    $error("unexpected result transfer: loss_percent %0d", m_tdata[13:0]);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = loss_expected.pop_front();
                    results_checked <= results_checked + 1;
                    if (m_tdata[13:0] !== want.loss)
                    begin
                        $error("loss_percent mismatch for inputs %h: expected %0d, actual %0d",
                               want.meas, want.loss, m_tdata[13:0]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                fresh.meas = s_tdata;
                fresh.loss = predict_loss(s_tdata);
                if (fresh.loss == 14'd0)
                    clamp_low <= clamp_low + 1;
                if (fresh.loss == 14'(LOSS_MAX))
                    clamp_high <= clamp_high + 1;
                loss_expected.push_back(fresh);
            end
            outstanding <= loss_expected.size();
        end
    end

endmodule

// ===== sim/nomograph_evaporation_loss_test.sv =====
// Testbench top for the evaporation loss nomograph: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module nomograph_evaporation_loss_test;

    localparam int N_CORNER    = 21;
    localparam int N_RANDOM    = 1830;
    localparam int N_QUIET     = 150;
    localparam int HOLD_AT     = 120;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN       = 40;
    localparam int LIMIT       = 400000;

    // {wind_speed, line_pressure, nozzle_size, vapor_deficit}
    localparam logic [63:0] CORNER_SETS [N_CORNER] = '{
        {16'd0,      16'd0,      16'd0,      16'd0},
        {16'hFFFF,   16'hFFFF,   16'hFFFF,   16'hFFFF},
        {16'hFFFF,   16'hFFFF,   16'd0,      16'd256},
        {16'd0,      16'd0,      16'hFFFF,   16'd0},
        {16'd0,      16'd5120,   16'd2048,   16'd0},
        {16'd3840,   16'd20480,  16'd16384,  16'd256},
        {16'd1,      16'd5121,   16'd2049,   16'd1},
        {16'd3839,   16'd20479,  16'd16383,  16'd255},
        {16'd0,      16'd5119,   16'd2047,   16'd0},
        {16'd3841,   16'd20481,  16'd16385,  16'd257},
        {16'd1792,   16'd12800,  16'd5120,   16'd128},
        {16'd256,    16'd6400,   16'd2560,   16'd26},
        {16'd3328,   16'd17920,  16'd12288,  16'd230},
        {16'hAAAA,   16'hAAAA,   16'hAAAA,   16'hAAAA},
        {16'h5555,   16'h5555,   16'h5555,   16'h5555},
        {16'd3584,   16'd19200,  16'd14336,  16'd243},
        {16'd128,    16'd5760,   16'd2304,   16'd13},
        {16'd2000,   16'd13000,  16'd7000,   16'd140},
        {16'd0,      16'd20480,  16'd16384,  16'd0},
        {16'd3840,   16'd5120,   16'd2048,   16'd256},
        {16'd8000,   16'd0,      16'd20000,  16'd256}
    };

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;   // vapor_deficit, nozzle_size, line_pressure, wind_speed
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // loss_percent, 2'b0

    int fail_count;
    int outstanding;
    int results_checked;
    int clamp_low;
    int clamp_high;
    int sent   = 0;
    int cycles = 0;
    bit quiet  = 1'b0;

    always #4 clk = ~clk;

    nomograph_evaporation_loss u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    nomograph_evaporation_loss_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .clamp_low       (clamp_low),
        .clamp_high      (clamp_high)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending", cycles, outstanding);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // mostly in-table values, some near multiples of 256 (breakpoints), some fully random
    function automatic logic [15:0] pick_measure(input int lo, input int hi);
        int sel;
        int val;
        int margin;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 16'($urandom);
        if (sel == 1)
        begin
            val = $urandom_range(lo / 256, hi / 256) * 256 + $urandom_range(0, 2) - 1;
            return 16'((val < 0) ? 0 : val);
        end
        margin = (hi - lo) / 16;
        val = $urandom_range((lo > margin) ? lo - margin : 0, hi + margin);
        return 16'(val);
    endfunction

    task automatic send_set(input logic [63:0] d);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        sent++;
    endtask

    // sink side: random stalls, one long hold-off to back the pipeline up
    initial
    begin : sink
        bit held;
        held = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (quiet)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else if (!held && sent >= HOLD_AT)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    initial
    begin : source
        logic [63:0] d;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_CORNER; i++)
            send_set(CORNER_SETS[i]);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i >= N_RANDOM - N_QUIET)
                quiet = 1'b1;
            d = {pick_measure(0, 3840), pick_measure(5120, 20480),
                 pick_measure(2048, 16384), pick_measure(0, 256)};
            send_set(d);
        end
        s_tvalid <= 1'b0;

        while (outstanding != 0 || sent != results_checked)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("%0d measurement sets sent, %0d loss results checked", sent, results_checked);
        $display("covered breakpoints, out-of-table inputs, %0d results clamped at 0, %0d at 40",
                 clamp_low, clamp_high);
        if (fail_count == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== nomograph_evaporation_loss.f =====
rtl/nel_pkg.sv
rtl/nel_div.sv
rtl/nomograph_evaporation_loss.sv
sim/nomograph_evaporation_loss_checker.sv
sim/nomograph_evaporation_loss_test.sv
